FILE: rtl/core/linear_interp_resampler_gain_macros.svh
// Assertion macros used by the resampler controller.
`ifndef LINEAR_INTERP_RESAMPLER_GAIN_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_GAIN_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LIRG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("resampler assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LIRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("resampler assertion failed");

`endif

FILE: rtl/core/lirg_pkg.sv
`default_nettype none

package lirg_pkg;

	// Gain is unsigned Q4.12.
	localparam int GAIN_BITS      = 16;
	localparam int GAIN_FRAC_BITS = 12;
	localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'd4096;

	// At most this many outputs per source frame.
	localparam int MAX_OUT = 8;
	localparam int CNT_W   = 4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 2'd1;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic issue;
		logic last;
		logic load_prev;
		logic load_cur;
		logic commit;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/lirg_ctrl.sv
`default_nettype none

`include "linear_interp_resampler_gain_macros.svh"

module lirg_ctrl #(
	parameter int PHASE_FRAC_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [PHASE_FRAC_BITS+3:0] step,
	input  wire logic                       adv,
	output lirg_pkg::cmd_t                  cmd,
	output logic [PHASE_FRAC_BITS-1:0]      frac
);

	localparam int PH_W = PHASE_FRAC_BITS + 5;
	localparam logic [PH_W-1:0] PHASE_ONE =
		{{(PH_W-PHASE_FRAC_BITS-1){1'b0}}, 1'b1, {PHASE_FRAC_BITS{1'b0}}};

	lirg_pkg::state_t state_q, state_d;
	logic [PH_W-1:0] phase_q;
	logic [PH_W-1:0] phase_next;
	logic [lirg_pkg::CNT_W-1:0] cnt_q;
	logic primed_q;
	logic accept;
	logic want_out;

	// Phase of the following output point and whether one is still due.
	assign phase_next = phase_q + {1'b0, step};
	assign want_out   = (phase_q < PHASE_ONE) &&
		(cnt_q < lirg_pkg::CNT_W'(lirg_pkg::MAX_OUT));
	assign accept     = in_valid && (state_q == lirg_pkg::ST_IDLE);
	assign frac       = phase_q[PHASE_FRAC_BITS-1:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lirg_pkg::ST_IDLE: begin
				if (accept && primed_q) begin
					state_d = lirg_pkg::ST_RUN;
				end
			end
			lirg_pkg::ST_RUN: begin
				if (!want_out) begin
					state_d = lirg_pkg::ST_IDLE;
				end
			end
			default: state_d = lirg_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			lirg_pkg::ST_IDLE: begin
				in_stall      = 1'b0;
				cmd.load_prev = accept && !primed_q;
				cmd.load_cur  = accept && primed_q;
			end
			lirg_pkg::ST_RUN: begin
				cmd.issue  = want_out && adv;
				cmd.last   = (phase_next >= PHASE_ONE) ||
					(cnt_q == lirg_pkg::CNT_W'(lirg_pkg::MAX_OUT - 1));
				cmd.commit = !want_out;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// State, phase accumulator, output count and priming flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lirg_pkg::ST_IDLE;
			phase_q  <= '0;
			cnt_q    <= '0;
			primed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				primed_q <= 1'b1;
			end
			if (cmd.load_cur) begin
				cnt_q <= '0;
			end else if (cmd.issue) begin
				cnt_q <= cnt_q + lirg_pkg::CNT_W'(1);
			end
			// The phase drops by one frame at the end of the run, floored at zero.
			if (cmd.issue) begin
				phase_q <= phase_next;
			end else if (cmd.commit) begin
				phase_q <= (phase_q >= PHASE_ONE) ? (phase_q - PHASE_ONE) : '0;
			end
		end
	end

	`LIRG_ASSERT_SAME(a_cnt_bounded, clk, arst_n, 1'b1,
		cnt_q <= lirg_pkg::CNT_W'(lirg_pkg::MAX_OUT))
	`LIRG_ASSERT_NEXT(a_run_starts_clean, clk, arst_n, cmd.load_cur,
		(state_q == lirg_pkg::ST_RUN) && (cnt_q == '0))
	`LIRG_ASSERT_NEXT(a_issue_counts, clk, arst_n, cmd.issue,
		cnt_q == ($past(cnt_q) + lirg_pkg::CNT_W'(1)))
	`LIRG_ASSERT_NEXT(a_commit_ends_run, clk, arst_n, cmd.commit,
		state_q == lirg_pkg::ST_IDLE)

endmodule

`default_nettype wire

FILE: rtl/core/lirg_dp.sv
`default_nettype none

module lirg_dp #(
	parameter int SAMPLE_BITS     = 16,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire lirg_pkg::cmd_t                       cmd,
	input  wire logic [PHASE_FRAC_BITS-1:0]           frac,
	input  wire logic signed [SAMPLE_BITS-1:0]        left_in,
	input  wire logic signed [SAMPLE_BITS-1:0]        right_in,
	input  wire logic [lirg_pkg::GAIN_BITS-1:0]       gain,
	input  wire logic                                 out_stall,
	output logic                                      adv,
	output logic                                      out_valid,
	output logic signed [SAMPLE_BITS-1:0]             left_out,
	output logic signed [SAMPLE_BITS-1:0]             right_out,
	output logic                                      last_of_run
);

	localparam int S   = SAMPLE_BITS;
	localparam int F   = PHASE_FRAC_BITS;
	localparam int IW  = S + F + 2;
	localparam int GW  = lirg_pkg::GAIN_BITS + 1;
	localparam int PW  = IW + GW;
	localparam int SH  = F + lirg_pkg::GAIN_FRAC_BITS;
	localparam logic signed [PW-1:0] ROUND = PW'(1) <<< (SH - 1);
	localparam logic signed [PW-1:0] SMAX  = (PW'(1) <<< (S - 1)) - PW'(1);
	localparam logic signed [PW-1:0] SMIN  = -SMAX - PW'(1);

	logic signed [S-1:0] in_d [2];
	logic signed [S-1:0] prev_q [2];
	logic signed [S-1:0] cur_q [2];
	logic signed [S-1:0] a_s1 [2];
	logic signed [IW-1:0] dprod_s1 [2];
	logic signed [PW-1:0] prod_s2 [2];
	logic signed [S-1:0] res_q [2];
	logic signed [F:0] frac_s;
	logic signed [GW-1:0] gain_s;
	logic valid_s1, valid_s2, valid_q;
	logic last_s1, last_s2, last_q;

	assign in_d[0] = left_in;
	assign in_d[1] = right_in;
	assign frac_s  = signed'({1'b0, frac});
	assign gain_s  = signed'({1'b0, gain});

	// The whole pipeline moves unless a result waits on a stalled receiver.
	assign adv = !(valid_q && out_stall);

	// Stage valids and end-of-run marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= cmd.last;
			last_s2 <= last_s1;
			last_q  <= last_s2;
		end
	end

	for (genvar i = 0; i < 2; i++) begin : g_lane
		logic signed [S:0] diff;
		logic signed [IW-1:0] dprod_d;
		logic signed [IW-1:0] interp;
		logic signed [PW-1:0] prod_d;
		logic signed [PW-1:0] rnd;
		logic signed [PW-1:0] q;

		// Previous and current source frames.
		always_ff @(posedge clk) begin
			if (cmd.load_prev) begin
				prev_q[i] <= in_d[i];
			end else if (cmd.commit) begin
				prev_q[i] <= cur_q[i];
			end
			if (cmd.load_cur) begin
				cur_q[i] <= in_d[i];
			end
		end

		// Stage one: slope times fractional phase.
		assign diff    = {cur_q[i][S-1], cur_q[i]} - {prev_q[i][S-1], prev_q[i]};
		assign dprod_d = IW'(diff) * IW'(frac_s);

		// Stage two: interpolated point in Q.F, then the gain.
		assign interp = {{(IW-S-F){a_s1[i][S-1]}}, a_s1[i], {F{1'b0}}} + dprod_s1[i];
		assign prod_d = PW'(interp) * PW'(gain_s);

		// Stage three: round half up, then clamp to the sample range.
		assign rnd = prod_s2[i] + ROUND;
		assign q   = rnd >>> SH;

		always_ff @(posedge clk) begin
			if (adv) begin
				a_s1[i]     <= prev_q[i];
				dprod_s1[i] <= dprod_d;
				prod_s2[i]  <= prod_d;
				if (q > SMAX) begin
					res_q[i] <= SMAX[S-1:0];
				end else if (q < SMIN) begin
					res_q[i] <= SMIN[S-1:0];
				end else begin
					res_q[i] <= q[S-1:0];
				end
			end
		end
	end

	assign out_valid   = valid_q;
	assign left_out    = res_q[0];
	assign right_out   = res_q[1];
	assign last_of_run = last_q;

endmodule

`default_nettype wire

FILE: rtl/core/linear_interp_resampler_gain.sv
// Stereo linear-interpolation sample rate converter with gain.
// Source frames arrive on the in channel (in_valid, in_stall, left_in, right_in);
// a request is taken when in_valid is high and in_stall low. Interpolated,
// gain-scaled and saturated frames leave on the out channel (out_valid, out_stall,
// left_out, right_out, last_of_run); last_of_run marks the final output of a frame.
// phase_step (index 0, unsigned Q4.F) and gain (index 1, unsigned Q4.12) are written
// through the cfg channel, which is always ready; other indexes are ignored.
// The first frame after reset only primes the previous-frame store.
// A later frame producing n outputs (0 to 8) is accepted, has each output point issued,
// then has its phase advanced. Outputs are issued one per cycle while the out channel
// does not stall, into a three-stage datapath (slope multiply, gain multiply, round
// and clamp) with registered stages. A stall on the out channel while a result waits
// freezes the whole datapath and holds the controller's issue; the input is not taken
// again until the current frame's outputs are issued.
// Reset clears the phase, the primed flag and all valids, and restores the default
// step (44100/48000) and unity gain.
`default_nettype none

module linear_interp_resampler_gain #(
	parameter int SAMPLE_BITS     = 16,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]        left_in,
	input  wire logic signed [SAMPLE_BITS-1:0]        right_in,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [SAMPLE_BITS-1:0]             left_out,
	output logic signed [SAMPLE_BITS-1:0]             right_out,
	output logic                                      last_of_run,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [lirg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [((PHASE_FRAC_BITS + 4 > lirg_pkg::GAIN_BITS) ?
		(PHASE_FRAC_BITS + 4) : lirg_pkg::GAIN_BITS)-1:0] cfg_data
);

	localparam int STEP_W = PHASE_FRAC_BITS + 4;
	localparam longint STEP_RST = (64'(44100) << PHASE_FRAC_BITS) / 64'(48000);

	logic [STEP_W-1:0] step_q;
	logic [lirg_pkg::GAIN_BITS-1:0] gain_q;
	lirg_pkg::cmd_t cmd;
	logic [PHASE_FRAC_BITS-1:0] frac;
	logic adv;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_W'(STEP_RST);
			gain_q <= lirg_pkg::GAIN_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lirg_pkg::REG_PHASE_STEP: step_q <= cfg_data[STEP_W-1:0];
				lirg_pkg::REG_GAIN:       gain_q <= cfg_data[lirg_pkg::GAIN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	lirg_ctrl #(
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.step    (step_q),
		.adv     (adv),
		.cmd     (cmd),
		.frac    (frac)
	);

	lirg_dp #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.frac       (frac),
		.left_in    (left_in),
		.right_in   (right_in),
		.gain       (gain_q),
		.out_stall  (out_stall),
		.adv        (adv),
		.out_valid  (out_valid),
		.left_out   (left_out),
		.right_out  (right_out),
		.last_of_run(last_of_run)
	);

endmodule

`default_nettype wire
